### hdl/stlph_pkg.sv
package stlph_pkg;

  localparam int TABLE_SIZE_DEF = 11;
  localparam int ADDR_W         = 16;
  localparam int SLOT_W         = 6;
  localparam int HEAD_W         = 64;
  localparam int TAIL_W         = 8;
  localparam int STATUS_W       = 3;
  localparam int HASH_KEYS      = 128;
  localparam int HASH_KEY_W     = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_ADDR = 3'd4;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] sym_address;
    logic [HEAD_W-1:0] label_head;
    logic [TAIL_W-1:0] label_tail;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   found_address;
  } out_item_t;

  // Probe token that walks from cell to cell.
  typedef struct packed {
    logic              active;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] found_address;
  } tok_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_REJECT
  } ctrl_state_t;

  // Home slot for every value of the low seven address bits, built by a
  // wrapping counter so that no division is needed.
  function automatic logic [HASH_KEYS-1:0][SLOT_W-1:0] build_home_lut(input int n);
    logic [HASH_KEYS-1:0][SLOT_W-1:0] lut;
    int r;
    r = 0;
    for (int j = 0; j < HASH_KEYS; j++) begin
      lut[j] = SLOT_W'(r);
      r = (r == n - 1) ? 0 : r + 1;
    end
    return lut;
  endfunction

  // Clear every label character after the first NUL.
  function automatic logic [HEAD_W+TAIL_W-1:0] cut_label(input logic [HEAD_W-1:0] head,
                                                          input logic [TAIL_W-1:0] tail);
    logic [HEAD_W-1:0] h;
    logic              alive;
    h     = head;
    alive = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (head[HEAD_W-1-8*k -: 8] == 8'd0) alive = 1'b0;
      if (!alive) h[HEAD_W-1-8*k -: 8] = 8'd0;
    end
    return {h, (alive ? tail : 8'd0)};
  endfunction

endpackage

### hdl/symbol_table_linear_probe_hash.sv
// An insert finishes when the probe token meets an empty cell or has visited every slot;
// a search always visits every slot; a zero-address insert is rejected through S_REJECT.
// busy is high from the accept edge until the result is registered, and a new item is only
// accepted while busy is low; the probe token visits one cell per cycle.
// Reset (synchronous, rst_n low) empties every slot and idles the controller.
// The receiver cannot stall: each result is shown for exactly one cycle.
module symbol_table_linear_probe_hash import stlph_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // The table is a ring of cells, each owning one slot. An accepted item other
  // than a zero-address insert drops a single probe token into one cell: the
  // home slot for an insert, slot zero for a search. Every cycle the token
  // moves one cell forward, wrapping from the last cell to the first.
  //
  // On an insert the first empty cell the token meets claims the item and
  // the controller retires the token at once. On a search the token sweeps
  // all cells in index order, and each matching cell overwrites the match
  // carried by the token, so the last match in index order is reported.

  tok_t                  tok_out [TABLE_SIZE];
  tok_t                  tok_sum;
  in_item_t              cmd;
  logic                  kill;
  logic [TABLE_SIZE-1:0] inject;

  stlph_ctrl #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .tok_sum  (tok_sum),
    .busy     (busy),
    .cmd      (cmd),
    .kill     (kill),
    .inject   (inject),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    localparam int PREV = (i == 0) ? TABLE_SIZE - 1 : i - 1;
    stlph_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .kill   (kill),
      .inject (inject[i]),
      .tok_in (tok_out[PREV]),
      .tok_out(tok_out[i])
    );
  end

  // Only one cell holds the token, and idle cells drive zero, so an OR
  // gathers the token as it leaves whichever cell holds it this cycle.
  always_comb begin
    tok_sum = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tok_sum = tok_sum | tok_out[i];
    end
  end

endmodule

### hdl/stlph_cell.sv
module stlph_cell import stlph_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t cmd,
  input  logic     kill,
  input  logic     inject,
  input  tok_t     tok_in,
  output tok_t     tok_out
);

  tok_t              tok_r, tok_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [HEAD_W-1:0] head_r;
  logic [TAIL_W-1:0] tail_r;
  logic              empty, match, write_en;

  assign empty    = (addr_r == '0);
  assign match    = !empty && (head_r == cmd.label_head) && (tail_r == cmd.label_tail);
  assign write_en = tok_r.active && (cmd.op == OP_INSERT) && empty;

  always_comb begin
    tok_out = '0;
    if (tok_r.active) begin
      tok_out = tok_r;
      if (cmd.op == OP_INSERT) begin
        if (empty) begin
          tok_out.hit  = 1'b1;
          tok_out.slot = SLOT_W'(IDX);
        end
      end else if (match) begin
        tok_out.hit           = 1'b1;
        tok_out.slot          = SLOT_W'(IDX);
        tok_out.found_address = addr_r;
      end
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (kill) begin
      tok_nxt = '0;
    end else if (inject) begin
      tok_nxt        = '0;
      tok_nxt.active = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= '0;
      addr_r <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (write_en) addr_r <= cmd.sym_address;
    end
  end

  // Labels are only compared where the address marks the slot occupied.
  always_ff @(posedge clk) begin
    if (write_en) begin
      head_r <= cmd.label_head;
      tail_r <= cmd.label_tail;
    end
  end

endmodule

### hdl/stlph_ctrl.sv
module stlph_ctrl import stlph_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  in_item_t              in_item,
  input  tok_t                  tok_sum,
  output logic                  busy,
  output in_item_t              cmd,
  output logic                  kill,
  output logic [TABLE_SIZE-1:0] inject,
  output logic                  out_valid,
  output out_item_t             out_item
);

  localparam int CNT_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [HASH_KEYS-1:0][SLOT_W-1:0] HOME_LUT = build_home_lut(TABLE_SIZE);

  ctrl_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  in_item_t           cmd_r, cmd_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic               accept, done;
  logic [SLOT_W-1:0]  home;
  logic [HEAD_W+TAIL_W-1:0] cut;

  assign accept = start && (state_r == S_IDLE);
  assign home   = HOME_LUT[in_item.sym_address[HASH_KEY_W-1:0]];
  assign cut    = cut_label(in_item.label_head, in_item.label_tail);

  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (in_item.op == OP_SEARCH) begin
        inject[i] = accept && (i == 0);
      end else begin
        inject[i] = accept && (in_item.sym_address != '0) && (home == SLOT_W'(i));
      end
    end
  end

  assign done = ((cmd_r.op == OP_INSERT) && tok_sum.hit) ||
                (cnt_r == CNT_W'(TABLE_SIZE - 1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    kill          = 1'b0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt.op          = in_item.op;
          cmd_nxt.sym_address = in_item.sym_address;
          {cmd_nxt.label_head, cmd_nxt.label_tail} = cut;
          cnt_nxt             = '0;
          if ((in_item.op == OP_INSERT) && (in_item.sym_address == '0)) begin
            state_nxt = S_REJECT;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (done) begin
          kill                       = 1'b1;
          out_valid_nxt              = 1'b1;
          out_item_nxt.slot          = tok_sum.hit ? tok_sum.slot : '0;
          out_item_nxt.found_address = '0;
          if (cmd_r.op == OP_INSERT) begin
            out_item_nxt.status = tok_sum.hit ? ST_INSERTED : ST_FULL;
          end else begin
            out_item_nxt.status        = tok_sum.hit ? ST_FOUND : ST_NOT_FOUND;
            out_item_nxt.found_address = tok_sum.hit ? tok_sum.found_address : '0;
          end
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_REJECT: begin
        out_valid_nxt              = 1'b1;
        out_item_nxt.status        = ST_ZERO_ADDR;
        out_item_nxt.slot          = '0;
        out_item_nxt.found_address = '0;
        state_nxt                  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cmd       = cmd_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
